/* hw/rtl/gf2tab_pkg.sv */
// ----------------------------------------------------------------------------
// GF(2) transpose product package
// Widths and the control bundle that the top level shares with its cells.
// ----------------------------------------------------------------------------
package gf2tab_pkg;

	// Width of the A, B and product words on the ports.
	localparam int WORD_W = 64;

	// Width of the product row index on the output port.
	localparam int ROW_W = 6;

	// Default block size: number of accumulator rows and used word bits.
	localparam int BLOCK_BITS_DEF = 64;

	// Per-cycle command from the controller to every cell of the chain.
	typedef struct packed {
		logic take;   // an input item is accepted this cycle
		logic shift;  // drain step: each cell loads its upper neighbor, the top cell zeros
	} cell_ctrl_t;

endpackage

/* hw/rtl/gf2_transpose_a_times_b.sv */
// ----------------------------------------------------------------------------
// GF(2) transpose(A) times B, one block
// Accumulates one BLOCK_BITS x BLOCK_BITS block of transpose(A)*B over GF(2)
// in a chain of row cells and streams the rows out after the last item.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_ready  | a_row_word, b_row_word, final_row
//  output  | out_valid / out_ready| product_word, product_row, final_word
//
// Items without the final mark are absorbed as they arrive, so they
// stream in back to back. An item with the final mark is absorbed the
// same way and is then followed by a drain of BLOCK_BITS rows, in which
// the cells shift one row per cycle toward the output register unless the
// output stalls; the input is not ready during the drain. Reset clears
// the accumulator and the output register valid. An output stall holds
// the drain in place; the input is ready again as soon as the last row
// has entered the output register.
//
// Each cell owns accumulator row i. On every accepted item, all cells
// in parallel XOR the masked B word into their row when bit i of the A word
// is set. Bits of either word at or above BLOCK_BITS are ignored, so the
// upper product bits are always zero. The drain shifts zeros in from the
// top of the chain, which leaves the accumulator cleared for the next pass.
//
module gf2_transpose_a_times_b #(
	parameter int BLOCK_BITS = gf2tab_pkg::BLOCK_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [gf2tab_pkg::WORD_W-1:0]  a_row_word,
	input  logic [gf2tab_pkg::WORD_W-1:0]  b_row_word,
	input  logic                           final_row,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [gf2tab_pkg::WORD_W-1:0]  product_word,
	output logic [gf2tab_pkg::ROW_W-1:0]   product_row,
	output logic                           final_word
);
	import gf2tab_pkg::*;

	localparam int CNT_W = $clog2(BLOCK_BITS);

	typedef enum logic [1:0] {
		ST_ACCUM = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   out_valid_q;
	logic [BLOCK_BITS-1:0]  out_word_q;
	logic [CNT_W-1:0]       out_row_q;
	logic                   out_final_q;

	cell_ctrl_t             ctrl;
	logic                   in_take;
	logic                   out_load;
	logic                   cnt_last;
	logic [BLOCK_BITS-1:0]  b_masked;
	logic [BLOCK_BITS-1:0]  row_w [BLOCK_BITS];

	// The input is open only while accumulating. A drain step happens
	// whenever the output register is empty or being emptied.
	assign in_ready  = (state_q == ST_ACCUM);
	assign in_take   = in_valid && in_ready;
	assign out_load  = (state_q == ST_DRAIN) && (!out_valid_q || out_ready);
	assign cnt_last  = (cnt_q == CNT_W'(BLOCK_BITS - 1));
	assign b_masked  = b_row_word[BLOCK_BITS-1:0];

	assign ctrl.take  = in_take;
	assign ctrl.shift = out_load;

	// The chain of row cells. Cell 0 feeds the output register; the top
	// cell shifts in zeros so that the drain clears the accumulator.
	for (genvar i = 0; i < BLOCK_BITS; i++) begin : g_cell
		logic [BLOCK_BITS-1:0] next_row;

		if (i == BLOCK_BITS - 1) begin : g_top
			assign next_row = '0;
		end else begin : g_mid
			assign next_row = row_w[i+1];
		end

		gf2tab_cell #(
			.BLOCK_BITS (BLOCK_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.sel_bit  (a_row_word[i]),
			.b_word   (b_masked),
			.next_row (next_row),
			.row      (row_w[i])
		);
	end

	// Pass control: accumulate until the final item, then drain all rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_ACCUM: begin
					if (in_take && final_row) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (out_load) begin
						if (cnt_last) begin
							cnt_q   <= '0;
							state_q <= ST_ACCUM;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_ACCUM;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	// Output register: decouples the chain from a stalling consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q  <= row_w[0];
			out_row_q   <= cnt_q;
			out_final_q <= cnt_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign product_word = WORD_W'(out_word_q);
	assign product_row  = ROW_W'(out_row_q);
	assign final_word   = out_final_q;

	// A final item always starts a drain, so the input closes next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && final_row) |=> !in_ready)
		else $error("input still open after the final item of a pass");

	// Rows of a pass leave in order with no gaps while the consumer takes them.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !final_word) |=>
			(out_valid && (product_row == ROW_W'($past(product_row) + ROW_W'(1)))))
		else $error("product rows not emitted in consecutive order");

	// The final mark sits on the last row of the block.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && final_word) |-> (product_row == ROW_W'(BLOCK_BITS - 1)))
		else $error("final mark on a row other than the last");

endmodule

/* hw/rtl/gf2tab_cell.sv */
// ----------------------------------------------------------------------------
// GF(2) accumulator cell
// Holds one accumulator row. It XORs in the B word when its A bit is set,
// and during a drain it takes over the row of its upper neighbor.
// ----------------------------------------------------------------------------
module gf2tab_cell #(
	parameter int BLOCK_BITS = gf2tab_pkg::BLOCK_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gf2tab_pkg::cell_ctrl_t  ctrl,
	input  logic                    sel_bit,
	input  logic [BLOCK_BITS-1:0]   b_word,
	input  logic [BLOCK_BITS-1:0]   next_row,
	output logic [BLOCK_BITS-1:0]   row
);
	import gf2tab_pkg::*;

	logic [BLOCK_BITS-1:0] row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctrl.shift) begin
			row_q <= next_row;
		end else if (ctrl.take && sel_bit) begin
			row_q <= row_q ^ b_word;
		end
	end

	assign row = row_q;

endmodule
